[rtl/hbrs1_pkg.sv]
// Shared types, constants and the usage-to-set-1 code table for the report translator.
`default_nettype none

package hbrs1_pkg;

    localparam int MOD_COUNT = 8;
    localparam int MAX_SLOTS = 6;

    localparam logic       CMD_REPORT     = 1'b0;
    localparam logic       CMD_ATTACH     = 1'b1;
    localparam logic [7:0] PREFIX_BYTE    = 8'hE0;
    localparam logic [7:0] MOD_BASE       = 8'hE0;
    localparam logic [7:0] ROLLOVER_USAGE = 8'h01;
    localparam logic [7:0] LOWEST_KEY     = 8'h04;
    localparam logic [7:0] PREFIX_FLAG    = 8'h80;
    localparam logic [7:0] BREAK_BIT      = 8'h80;

    // One key event: optional E0 prefix, then the make or break byte.
    typedef struct packed {
        logic       prefix;
        logic [7:0] code_byte;
    } evt_t;

    // Control from the diff logic to the state registers.
    typedef struct packed {
        logic commit;
        logic attach;
    } ctl_t;

    // Bit 7 of the result marks a prefixed key; zero means no code.
    function automatic logic [7:0] code_lookup(input logic [7:0] usage);
        logic [7:0] c;
        case (usage)
            8'h04: c = 8'h1E;  8'h05: c = 8'h30;  8'h06: c = 8'h2E;  8'h07: c = 8'h20;
            8'h08: c = 8'h12;  8'h09: c = 8'h21;  8'h0A: c = 8'h22;  8'h0B: c = 8'h23;
            8'h0C: c = 8'h17;  8'h0D: c = 8'h24;  8'h0E: c = 8'h25;  8'h0F: c = 8'h26;
            8'h10: c = 8'h32;  8'h11: c = 8'h31;  8'h12: c = 8'h18;  8'h13: c = 8'h19;
            8'h14: c = 8'h10;  8'h15: c = 8'h13;  8'h16: c = 8'h1F;  8'h17: c = 8'h14;
            8'h18: c = 8'h16;  8'h19: c = 8'h2F;  8'h1A: c = 8'h11;  8'h1B: c = 8'h2D;
            8'h1C: c = 8'h15;  8'h1D: c = 8'h2C;
            8'h1E: c = 8'h02;  8'h1F: c = 8'h03;  8'h20: c = 8'h04;  8'h21: c = 8'h05;
            8'h22: c = 8'h06;  8'h23: c = 8'h07;  8'h24: c = 8'h08;  8'h25: c = 8'h09;
            8'h26: c = 8'h0A;  8'h27: c = 8'h0B;
            8'h28: c = 8'h1C;  8'h29: c = 8'h01;  8'h2A: c = 8'h0E;  8'h2B: c = 8'h0F;
            8'h2C: c = 8'h39;  8'h2D: c = 8'h0C;  8'h2E: c = 8'h0D;  8'h2F: c = 8'h1A;
            8'h30: c = 8'h1B;  8'h31: c = 8'h2B;  8'h32: c = 8'h2B;  8'h33: c = 8'h27;
            8'h34: c = 8'h28;  8'h35: c = 8'h29;  8'h36: c = 8'h33;  8'h37: c = 8'h34;
            8'h38: c = 8'h35;  8'h39: c = 8'h3A;
            8'h3A: c = 8'h3B;  8'h3B: c = 8'h3C;  8'h3C: c = 8'h3D;  8'h3D: c = 8'h3E;
            8'h3E: c = 8'h3F;  8'h3F: c = 8'h40;  8'h40: c = 8'h41;  8'h41: c = 8'h42;
            8'h42: c = 8'h43;  8'h43: c = 8'h44;  8'h44: c = 8'h57;  8'h45: c = 8'h58;
            8'h47: c = 8'h46;
            8'h49: c = 8'h52 | PREFIX_FLAG;  8'h4A: c = 8'h47 | PREFIX_FLAG;
            8'h4B: c = 8'h49 | PREFIX_FLAG;  8'h4C: c = 8'h53 | PREFIX_FLAG;
            8'h4D: c = 8'h4F | PREFIX_FLAG;  8'h4E: c = 8'h51 | PREFIX_FLAG;
            8'h4F: c = 8'h4D | PREFIX_FLAG;  8'h50: c = 8'h4B | PREFIX_FLAG;
            8'h51: c = 8'h50 | PREFIX_FLAG;  8'h52: c = 8'h48 | PREFIX_FLAG;
            8'h53: c = 8'h45;  8'h54: c = 8'h35 | PREFIX_FLAG;  8'h55: c = 8'h37;
            8'h56: c = 8'h4A;  8'h57: c = 8'h4E;  8'h58: c = 8'h1C | PREFIX_FLAG;
            8'h59: c = 8'h4F;  8'h5A: c = 8'h50;  8'h5B: c = 8'h51;  8'h5C: c = 8'h4B;
            8'h5D: c = 8'h4C;  8'h5E: c = 8'h4D;  8'h5F: c = 8'h47;  8'h60: c = 8'h48;
            8'h61: c = 8'h49;  8'h62: c = 8'h52;  8'h63: c = 8'h53;
            8'h64: c = 8'h56;
            8'hE0: c = 8'h1D;  8'hE1: c = 8'h2A;  8'hE2: c = 8'h38;
            8'hE3: c = 8'h5B | PREFIX_FLAG;  8'hE4: c = 8'h1D | PREFIX_FLAG;
            8'hE5: c = 8'h36;  8'hE6: c = 8'h38 | PREFIX_FLAG;  8'hE7: c = 8'h5C | PREFIX_FLAG;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Build the event for a looked-up code: strip the prefix flag, set break bit on release.
    function automatic evt_t make_evt(input logic [7:0] code, input logic make);
        evt_t e;
        e.prefix    = code[7];
        e.code_byte = make ? (code & ~PREFIX_FLAG) : (code | BREAK_BIT);
        return e;
    endfunction

endpackage

`default_nettype wire

[rtl/hbrs1_diff.sv]
// Compares one report with the stored report and lists the key events it causes.
`default_nettype none

module hbrs1_diff #(
    parameter int KEY_SLOTS = 6
) (
    input  wire logic               cmd,
    input  wire logic [7:0]         mods,
    input  wire logic [7:0]         keys [KEY_SLOTS],
    input  wire logic [7:0]         prior_mods,
    input  wire logic [7:0]         prior_keys [KEY_SLOTS],
    output hbrs1_pkg::evt_t         evt [hbrs1_pkg::MOD_COUNT + 2*KEY_SLOTS],
    output logic [hbrs1_pkg::MOD_COUNT + 2*KEY_SLOTS-1:0] evt_en,
    output hbrs1_pkg::ctl_t         ctl
);

    localparam int MC = hbrs1_pkg::MOD_COUNT;

    logic       all_roll;
    logic       report;
    logic [7:0] code;
    logic       held;

    always_comb
    begin
        all_roll = 1'b1;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (keys[i] != hbrs1_pkg::ROLLOVER_USAGE)
                all_roll = 1'b0;
        end
        report     = (cmd == hbrs1_pkg::CMD_REPORT) && !all_roll;
        ctl.commit = report;
        ctl.attach = (cmd == hbrs1_pkg::CMD_ATTACH);

        // Modifier bits, lowest first.
        for (int b = 0; b < MC; b++)
        begin
            code      = hbrs1_pkg::code_lookup(hbrs1_pkg::MOD_BASE + 8'(b));
            evt[b]    = hbrs1_pkg::make_evt(code, mods[b]);
            evt_en[b] = report && (mods[b] != prior_mods[b]) && (code != 8'h00);
        end

        // Releases in old slot order.
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            held = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (keys[j] == prior_keys[i])
                    held = 1'b1;
            end
            code           = hbrs1_pkg::code_lookup(prior_keys[i]);
            evt[MC + i]    = hbrs1_pkg::make_evt(code, 1'b0);
            evt_en[MC + i] = report && (prior_keys[i] >= hbrs1_pkg::LOWEST_KEY) && !held
                             && (code != 8'h00);
        end

        // Presses in new slot order.
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            held = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (prior_keys[j] == keys[i])
                    held = 1'b1;
            end
            code                       = hbrs1_pkg::code_lookup(keys[i]);
            evt[MC + KEY_SLOTS + i]    = hbrs1_pkg::make_evt(code, 1'b1);
            evt_en[MC + KEY_SLOTS + i] = report && (keys[i] >= hbrs1_pkg::LOWEST_KEY) && !held
                                         && (code != 8'h00);
        end
    end

endmodule

`default_nettype wire

[rtl/hid_boot_report_to_set1_scancodes_top.sv]
// Top level: USB HID boot keyboard report in, PS/2 scancode set-1 bytes out.
`default_nettype none

// Each input transaction is one boot keyboard report or an attach command. The report
// lands in an input register; once the job register is free, one pass of logic compares
// it with the stored previous report, updates that state and loads a job of up to
// 8 + 2*KEY_SLOTS key events (modifier changes bit 0 to 7, then releases, then presses).
// The job drains through a single output byte register, one set-1 byte per cycle while
// m_tready holds, an E0 prefix taking a byte of its own; a report makes 0 to 36 bytes
// with six slots. The byte lane sets the sustained rate. The next report is taken into
// the input register while the current job still drains, and moves into the job
// register in the cycle the last byte of the job is issued. An attach command, an
// all-rollover report and a report with no change make no bytes. tlast marks the final
// byte of a report; tuser carries the attached flag.
module hid_boot_report_to_set1_scancodes_top #(
    parameter int KEY_SLOTS = 6
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [0] cmd, [8:1] modifier_bits, [16:9] key_slot_0 ... [56:49] key_slot_5, [63:57] zero
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] scan_byte
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    // [0] is_attached
    output logic             m_tuser
);

    localparam int NUM_EVT = hbrs1_pkg::MOD_COUNT + 2*KEY_SLOTS;

    // Input register.
    logic       in_full_reg;
    logic       in_cmd_reg;
    logic [7:0] in_mods_reg;
    logic [7:0] in_keys_reg [KEY_SLOTS];

    // Stored previous report.
    logic [7:0] prior_mods_reg;
    logic [7:0] prior_keys_reg [KEY_SLOTS];
    logic       attached_reg;

    // Job of pending events.
    logic [NUM_EVT-1:0] job_en_reg, job_en_next;
    hbrs1_pkg::evt_t    job_evt_reg [NUM_EVT];
    logic               job_att_reg;
    logic               phase_reg, phase_next;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic       out_user_reg;

    hbrs1_pkg::evt_t    diff_evt [NUM_EVT];
    logic [NUM_EVT-1:0] diff_en;
    hbrs1_pkg::ctl_t    diff_ctl;

    logic [NUM_EVT-1:0] pick, rest;
    hbrs1_pkg::evt_t    cur;
    logic               emit_prefix;
    logic               load_out;
    logic               job_done;
    logic               job_free;
    logic               move;

    hbrs1_diff #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_diff (
        .cmd        (in_cmd_reg),
        .mods       (in_mods_reg),
        .keys       (in_keys_reg),
        .prior_mods (prior_mods_reg),
        .prior_keys (prior_keys_reg),
        .evt        (diff_evt),
        .evt_en     (diff_en),
        .ctl        (diff_ctl)
    );

    // Pick the lowest pending event; rest is what remains once it is done.
    always_comb
    begin
        pick = job_en_reg & ~(job_en_reg - NUM_EVT'(1));
        rest = job_en_reg & (job_en_reg - NUM_EVT'(1));
        cur  = '0;
        for (int i = 0; i < NUM_EVT; i++)
        begin
            if (pick[i])
                cur = cur | job_evt_reg[i];
        end
        emit_prefix = cur.prefix && !phase_reg;
        load_out    = (job_en_reg != '0) && (!out_valid_reg || m_tready);
        job_done    = load_out && !emit_prefix && (rest == '0);
        job_free    = (job_en_reg == '0) || job_done;
        move        = in_full_reg && job_free;
        s_tready    = !in_full_reg || move;
    end

    // Next job mask and prefix phase.
    always_comb
    begin
        job_en_next = job_en_reg;
        phase_next  = phase_reg;
        if (load_out)
        begin
            phase_next = emit_prefix;
            if (!emit_prefix)
                job_en_next = rest;
        end
        if (move)
            job_en_next = diff_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg    <= 1'b0;
            job_en_reg     <= '0;
            phase_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            prior_mods_reg <= '0;
            attached_reg   <= 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++)
                prior_keys_reg[i] <= '0;
        end
        else
        begin
            // Input register: capture a transaction, drop it once it moves on.
            if (s_tvalid && s_tready)
                in_full_reg <= 1'b1;
            else if (move)
                in_full_reg <= 1'b0;

            job_en_reg <= job_en_next;
            phase_reg  <= phase_next;

            // Stored report: clear on attach, advance on a committed report.
            if (move)
            begin
                if (diff_ctl.attach)
                begin
                    prior_mods_reg <= '0;
                    attached_reg   <= 1'b1;
                    for (int i = 0; i < KEY_SLOTS; i++)
                        prior_keys_reg[i] <= '0;
                end
                else if (diff_ctl.commit)
                begin
                    prior_mods_reg <= in_mods_reg;
                    for (int i = 0; i < KEY_SLOTS; i++)
                        prior_keys_reg[i] <= in_keys_reg[i];
                end
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg  <= s_tdata[0];
            in_mods_reg <= s_tdata[8:1];
            for (int i = 0; i < KEY_SLOTS; i++)
                in_keys_reg[i] <= s_tdata[9 + 8*i +: 8];
        end
        if (move)
        begin
            job_att_reg <= attached_reg;
            for (int i = 0; i < NUM_EVT; i++)
                job_evt_reg[i] <= diff_evt[i];
        end
        if (load_out)
        begin
            out_data_reg <= emit_prefix ? hbrs1_pkg::PREFIX_BYTE : cur.code_byte;
            out_last_reg <= !emit_prefix && (rest == '0);
            out_user_reg <= job_att_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // A prefix byte is never the final byte of a report (no break code reaches E0).
    a_prefix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata == hbrs1_pkg::PREFIX_BYTE) |-> !m_tlast)
        else $error("prefix byte flagged as last of run");

    // The prefix phase is only open while its event is still pending.
    a_phase_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (job_en_reg != '0))
        else $error("prefix phase without pending event");

    // Issuing the last byte of a job closes the prefix phase.
    a_done_closes_phase: assert property (@(posedge clk) disable iff (!rst_n)
        job_done |=> !phase_reg)
        else $error("prefix phase left open after job end");

    // A report waiting in the input register moves on when the job drains.
    a_move_on_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_full_reg && (job_en_reg == '0) |=> !in_full_reg || $past(s_tvalid))
        else $error("report stalled with an empty job");

endmodule

`default_nettype wire
